// ----- rtl/ceb_pkg.sv -----
// ----------------------------------------------------------------------------
// ceb_pkg - shared types and constants of the CSR edge search block
// Command codes, decoded operation record, result record and default sizes.
// ----------------------------------------------------------------------------
package ceb_pkg;

    // field widths of the item ports
    localparam int IN_W   = 14;   // write_index / write_value
    localparam int NODE_W = 10;   // src_node / dest_node / stored target
    localparam int IDX_W  = 13;   // edge_index

    // default graph sizes
    localparam int DEF_NUM_NODES = 1024;
    localparam int DEF_NUM_EDGES = 8192;

    // queue depths
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int RES_QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_WR_OFFSET = 2'd0,
        CMD_WR_TARGET = 2'd1,
        CMD_QUERY     = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        OP_WR_OFFSET = 2'd0,
        OP_WR_TARGET = 2'd1,
        OP_QUERY     = 2'd2,
        OP_MISS      = 2'd3
    } t_op_kind;

    // one decoded item between front and back
    typedef struct packed {
        t_op_kind              kind;
        logic [IN_W-1:0]       addr;   // store address, or source node of a query
        logic [IN_W-1:0]       value;
        logic [NODE_W-1:0]     dest;
    } t_op;

    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      edge_index;
    } t_res;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OFF_LO,
        BK_OFF_HI,
        BK_TGT_LO,
        BK_TGT_HI,
        BK_CHECK,
        BK_MID,
        BK_RESULT
    } t_bk_state;

endpackage

// ----- rtl/ceb_ram.sv -----
// ----------------------------------------------------------------------------
// ceb_ram - generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ceb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ceb_fifo.sv -----
// ----------------------------------------------------------------------------
// ceb_fifo - small register queue
// Push/full on the write side, pop/empty on the read side, head shown
// directly.
// ----------------------------------------------------------------------------
module ceb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/ceb_front.sv -----
// ----------------------------------------------------------------------------
// ceb_front - item decoder
// Classify accepted items: drop unused commands and out-of-range writes,
// mark queries with an out-of-range source as misses.
// ----------------------------------------------------------------------------
module ceb_front
    import ceb_pkg::*;
#(
    parameter int NUM_NODES = DEF_NUM_NODES,
    parameter int NUM_EDGES = DEF_NUM_EDGES
) (
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_command,
    input  logic [IN_W-1:0]   i_write_index,
    input  logic [IN_W-1:0]   i_write_value,
    input  logic [NODE_W-1:0] i_src_node,
    input  logic [NODE_W-1:0] i_dest_node,
    output logic              o_q_push,
    output t_op               o_q_op,
    input  logic              i_q_full
);

    logic keep;

    assign o_full = i_q_full;

    always_comb begin
        keep            = 1'b0;
        o_q_op.kind     = OP_MISS;
        o_q_op.addr     = i_write_index;
        o_q_op.value    = i_write_value;
        o_q_op.dest     = i_dest_node;
        unique case (t_cmd'(i_command))
            CMD_WR_OFFSET: begin
                o_q_op.kind = OP_WR_OFFSET;
                keep        = (32'(i_write_index) <= 32'(NUM_NODES));
            end
            CMD_WR_TARGET: begin
                o_q_op.kind = OP_WR_TARGET;
                keep        = (32'(i_write_index) < 32'(NUM_EDGES));
            end
            CMD_QUERY: begin
                keep        = 1'b1;
                o_q_op.addr = IN_W'(i_src_node);
                o_q_op.kind = (32'(i_src_node) >= 32'(NUM_NODES)) ? OP_MISS : OP_QUERY;
            end
            default: begin
                keep = 1'b0;   // unused command: absorb, no effect
            end
        endcase
    end

    assign o_q_push = i_push && !i_q_full && keep;

endmodule

// ----- rtl/ceb_back.sv -----
// ----------------------------------------------------------------------------
// ceb_back - store owner and search sequencer
// Apply store writes and run the range-halving edge search on one
// single-read edge memory.
// ----------------------------------------------------------------------------
module ceb_back
    import ceb_pkg::*;
#(
    parameter int NUM_NODES = DEF_NUM_NODES,
    parameter int NUM_EDGES = DEF_NUM_EDGES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_op  i_q_op,
    output logic o_q_pop,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);

    localparam int OFF_DEPTH = NUM_NODES + 1;
    localparam int OFF_AW    = $clog2(OFF_DEPTH);
    localparam int EDGE_AW   = $clog2(NUM_EDGES);
    localparam int PW        = $clog2(NUM_EDGES + 1);

    t_bk_state          r_state, n_state;
    logic [OFF_AW-1:0]  r_src,   n_src;
    logic [NODE_W-1:0]  r_dest,  n_dest;
    logic [PW-1:0]      r_base,  n_base;
    logic [EDGE_AW-1:0] r_lo,    n_lo;
    logic [EDGE_AW-1:0] r_hi,    n_hi;
    logic [EDGE_AW-1:0] r_mid,   n_mid;
    logic [NODE_W-1:0]  r_lv,    n_lv;
    logic [NODE_W-1:0]  r_rv,    n_rv;
    logic               r_found, n_found;
    logic [EDGE_AW-1:0] r_idx,   n_idx;

    logic               off_we, off_re;
    logic [OFF_AW-1:0]  off_raddr;
    logic [IN_W-1:0]    off_rdata;
    logic               edge_we, edge_re;
    logic [EDGE_AW-1:0] edge_raddr;
    logic [NODE_W-1:0]  edge_rdata;
    logic [PW-1:0]      hi_excl;
    logic [EDGE_AW-1:0] mid;

    function automatic logic [PW-1:0] clamp_off(input logic [IN_W-1:0] v);
        logic [PW-1:0] c;
        c = (32'(v) > 32'(NUM_EDGES)) ? PW'(NUM_EDGES) : PW'(v);
        return c;
    endfunction

    ceb_ram #(.WIDTH(IN_W), .DEPTH(OFF_DEPTH)) u_off_ram (
        .i_clk   (i_clk),
        .i_we    (off_we),
        .i_waddr (OFF_AW'(i_q_op.addr)),
        .i_wdata (i_q_op.value),
        .i_re    (off_re),
        .i_raddr (off_raddr),
        .o_rdata (off_rdata)
    );

    ceb_ram #(.WIDTH(NODE_W), .DEPTH(NUM_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (EDGE_AW'(i_q_op.addr)),
        .i_wdata (NODE_W'(i_q_op.value)),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    assign hi_excl = clamp_off(off_rdata);
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);

    always_comb begin
        n_state    = r_state;
        n_src      = r_src;
        n_dest     = r_dest;
        n_base     = r_base;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_lv       = r_lv;
        n_rv       = r_rv;
        n_found    = r_found;
        n_idx      = r_idx;
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        off_we     = 1'b0;
        off_re     = 1'b0;
        off_raddr  = OFF_AW'(i_q_op.addr);
        edge_we    = 1'b0;
        edge_re    = 1'b0;
        edge_raddr = r_lo;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_src   = OFF_AW'(i_q_op.addr);
                    n_dest  = i_q_op.dest;
                    unique case (i_q_op.kind)
                        OP_WR_OFFSET: off_we  = 1'b1;
                        OP_WR_TARGET: edge_we = 1'b1;
                        OP_QUERY: begin
                            off_re  = 1'b1;
                            n_state = BK_OFF_LO;
                        end
                        default: begin
                            n_found = 1'b0;
                            n_idx   = '0;
                            n_state = BK_RESULT;
                        end
                    endcase
                end
            end
            BK_OFF_LO: begin
                n_base    = clamp_off(off_rdata);
                off_re    = 1'b1;
                off_raddr = r_src + OFF_AW'(1);
                n_state   = BK_OFF_HI;
            end
            BK_OFF_HI: begin
                if (hi_excl <= r_base) begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = BK_RESULT;
                end else begin
                    n_lo       = EDGE_AW'(r_base);
                    n_hi       = EDGE_AW'(hi_excl - PW'(1));
                    edge_re    = 1'b1;
                    edge_raddr = EDGE_AW'(r_base);
                    n_state    = BK_TGT_LO;
                end
            end
            BK_TGT_LO: begin
                n_lv = edge_rdata;
                if (r_dest == edge_rdata) begin
                    n_found = 1'b1;
                    n_idx   = r_lo;
                    n_state = BK_RESULT;
                end else begin
                    edge_re    = 1'b1;
                    edge_raddr = r_hi;
                    n_state    = BK_TGT_HI;
                end
            end
            BK_TGT_HI: begin
                n_rv = edge_rdata;
                if (r_dest == edge_rdata) begin
                    n_found = 1'b1;
                    n_idx   = r_hi;
                    n_state = BK_RESULT;
                end else begin
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: begin
                if (r_lo >= r_hi || r_dest < r_lv || r_dest > r_rv) begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = BK_RESULT;
                end else begin
                    n_mid      = mid;
                    edge_re    = 1'b1;
                    edge_raddr = mid;
                    n_state    = BK_MID;
                end
            end
            BK_MID: begin
                if (r_dest == edge_rdata) begin
                    n_found = 1'b1;
                    n_idx   = r_mid;
                    n_state = BK_RESULT;
                end else if (r_dest < edge_rdata) begin
                    if (r_hi == r_mid) begin
                        n_found = 1'b0;
                        n_idx   = '0;
                        n_state = BK_RESULT;
                    end else begin
                        n_hi    = r_mid;
                        n_rv    = edge_rdata;
                        n_state = BK_CHECK;
                    end
                end else begin
                    if (r_lo == r_mid) begin
                        n_found = 1'b0;
                        n_idx   = '0;
                        n_state = BK_RESULT;
                    end else begin
                        n_lo    = r_mid;
                        n_lv    = edge_rdata;
                        n_state = BK_CHECK;
                    end
                end
            end
            BK_RESULT: begin
                // hold the answer until the result queue has room
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src   <= n_src;
        r_dest  <= n_dest;
        r_base  <= n_base;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_lv    <= n_lv;
        r_rv    <= n_rv;
        r_found <= n_found;
        r_idx   <= n_idx;
    end

    assign o_res.found      = r_found;
    assign o_res.edge_index = IDX_W'(r_idx);

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CHECK) |-> (r_lo <= r_hi))
        else $error("search range inverted");

    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_MID) |-> (r_mid >= r_lo && r_mid < r_hi))
        else $error("midpoint outside range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RESULT && !r_found) |-> (r_idx == '0))
        else $error("miss carries nonzero index");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_RESULT && i_res_full) |=>
            (r_state == BK_RESULT && $stable(r_found) && $stable(r_idx)))
        else $error("result lost while queue full");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == BK_IDLE && !i_q_empty))
        else $error("command taken while search busy");

endmodule

// ----- rtl/csr_edge_binary_search_top.sv -----
// ----------------------------------------------------------------------------
// csr_edge_binary_search_top - CSR graph store with edge lookup
// Holds row offsets and edge targets, answers edge-exists queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive the item fields with push high; a
//   transfer happens at a clock edge where push is high and full is low.
//   Command 0 writes a row offset, command 1 writes an edge target, command 2
//   queries an edge from i_src_node to i_dest_node. Writes and the unused
//   command give no result; each query gives exactly one, in order.
//   Result side is a queue: while empty is low, o_found/o_edge_index show
//   the oldest answer; it transfers at an edge where pop is high.
// Queueing and search steps:
//   A command queue of CMD_QUEUE_DEPTH entries sits in front of the search
//   sequencer. A write is applied as the sequencer takes it from the queue.
//   A query holds the sequencer, which takes no new item until its answer is
//   pushed: on the single-read edge memory with its registered read, it reads
//   the two row offsets, then the two range ends, then per halving a compare
//   and midpoint read, a last compare; empty ranges stop after the offsets.
// Reset (i_rst_n, synchronous, active low) empties both queues and idles the
//   sequencer; store contents are undefined until written.
// Stall: when the result queue is full the sequencer holds its answer and the
//   command queue keeps taking items until it fills, then full rises.
// ----------------------------------------------------------------------------
module csr_edge_binary_search_top
    import ceb_pkg::*;
#(
    parameter int NUM_NODES = DEF_NUM_NODES,
    parameter int NUM_EDGES = DEF_NUM_EDGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_command,
    input  logic [IN_W-1:0]   i_write_index,
    input  logic [IN_W-1:0]   i_write_value,
    input  logic [NODE_W-1:0] i_src_node,
    input  logic [NODE_W-1:0] i_dest_node,
    output logic              empty,
    input  logic              pop,
    output logic              o_found,
    output logic [IDX_W-1:0]  o_edge_index
);

    // decoded command path: front -> queue -> back
    logic q_push, q_full, q_pop, q_empty;
    t_op  q_in_op, q_out_op;

    // result path: back -> queue -> ports
    logic res_push, res_full;
    t_res res_in, res_out;

    // classify the item and drop those that change nothing
    ceb_front #(.NUM_NODES(NUM_NODES), .NUM_EDGES(NUM_EDGES)) u_front (
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_write_index (i_write_index),
        .i_write_value (i_write_value),
        .i_src_node    (i_src_node),
        .i_dest_node   (i_dest_node),
        .o_q_push      (q_push),
        .o_q_op        (q_in_op),
        .i_q_full      (q_full)
    );

    // decouple intake from the search so writes can queue behind a query
    ceb_fifo #(.WIDTH($bits(t_op)), .DEPTH(CMD_QUEUE_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_op),
        .o_empty (q_empty)
    );

    // apply writes and run the search
    ceb_back #(.NUM_NODES(NUM_NODES), .NUM_EDGES(NUM_EDGES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_op     (q_out_op),
        .o_q_pop    (q_pop),
        .o_res_push (res_push),
        .o_res      (res_in),
        .i_res_full (res_full)
    );

    // hold answers while the receiver stalls
    ceb_fifo #(.WIDTH($bits(t_res)), .DEPTH(RES_QUEUE_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_found      = res_out.found;
    assign o_edge_index = res_out.edge_index;

endmodule
